[src/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define MTSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true out of reset
`define MTSC_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[src/mtsc_pkg.sv]
// shared types and constants for the tetrahedral sum counter
// no dependencies
package mtsc_pkg;

    localparam int K_W = 8;
    localparam int T_W = 18;
    localparam int N_W = 16;

    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_TERM = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [3:0] BEST_INIT = 4'd8;
    localparam logic [3:0] BEST_STOP = 4'd2;

    typedef struct packed {
        logic [K_W-1:0] k1;
        logic [T_W-1:0] t1;
        logic [T_W-1:0] u1;
        logic [K_W-1:0] k2;
        logic [T_W-1:0] t2;
    } t_bounds;

endpackage

[src/mtsc_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module mtsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[src/mtsc_bounds.sv]
// tracks the search bounds k1 and k2 as n steps up by one
// depends on mtsc_pkg and assert_macros.svh
`include "assert_macros.svh"
module mtsc_bounds import mtsc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic [N_W-1:0] i_n,
    output t_bounds        o_bnd
);

    logic [K_W-1:0] r_k1, r_k2;
    logic [T_W-1:0] r_t1, r_u1, r_c, r_d;
    logic [T_W-1:0] r_t2, r_t2n, r_u2;
    logic [T_W:0]   m6;
    logic [T_W-1:0] m;
    logic [T_W-1:0] n_ext;

    assign n_ext = T_W'(i_n);
    assign m6    = ((T_W+1)'(i_n) << 2) + ((T_W+1)'(i_n) << 1);
    assign m     = T_W'(m6 >> 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1  <= '0;
            r_t1  <= '0;
            r_u1  <= T_W'(1);
            r_c   <= T_W'(1);
            r_d   <= T_W'(7);
            r_k2  <= K_W'(1);
            r_t2  <= T_W'(1);
            r_t2n <= T_W'(4);
            r_u2  <= T_W'(6);
        end else if (i_adv) begin
            if (r_c <= m) begin
                r_k1 <= r_k1 + K_W'(1);
                r_t1 <= r_t1 + r_u1;
                r_u1 <= r_u1 + T_W'(r_k1) + T_W'(2);
                r_c  <= r_c + r_d;
                r_d  <= r_d + (T_W'(r_k1) << 2) + (T_W'(r_k1) << 1) + T_W'(12);
            end
            if (r_t2n <= n_ext) begin
                r_k2  <= r_k2 + K_W'(1);
                r_t2  <= r_t2n;
                r_t2n <= r_t2n + r_u2;
                r_u2  <= r_u2 + T_W'(r_k2) + T_W'(3);
            end
        end
    end

    assign o_bnd = '{k1: r_k1, t1: r_t1, u1: r_u1, k2: r_k2, t2: r_t2};

    `MTSC_ASSERT(a_k_order, i_clk, i_rst_n, r_k1 <= r_k2, "k1 above k2")
    `MTSC_ASSERT(a_t_order, i_clk, i_rst_n, r_t2 < r_t2n, "k2 terms out of order")

endmodule

[src/min_tetrahedral_sum_count.sv]
// top level of the tetrahedral sum counter: control, count table, tie list
// depends on mtsc_pkg, mtsc_ram, mtsc_bounds and assert_macros.svh
//
// channel   | direction | handshake                | word
// ----------+-----------+--------------------------+-------------------------------
// request   | in        | start and not busy       | i_n_value
// result    | out       | o_valid, one cycle       | o_kind o_n_echo o_value o_last
// config    | in        | psel penable pwrite      | paddr pwdata, prdata read back
//
// an item passes prep, the walk over k1 to k2, the table write back, the header
// and one word per tie; the walk reads one count table entry per candidate k through
// the single table port, and stops early once the count is 2. errors go straight to
// the error word; tetrahedral n skip the walk and give a header and one term word.
// reset is synchronous; the count table is not cleared, entries below the expected n
// are always written before use. results cannot be stalled.
`include "assert_macros.svh"
module min_tetrahedral_sum_count import mtsc_pkg::*; #(
    parameter int MAX_TABLE = 65536,
    parameter int MAX_TIES  = 39
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [N_W-1:0] i_n_value,
    output logic           o_valid,
    output logic [1:0]     o_kind,
    output logic [N_W-1:0] o_n_echo,
    output logic [7:0]     o_value,
    output logic           o_last,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int AW = (MAX_TABLE > 1) ? $clog2(MAX_TABLE) : 1;
    localparam int TW = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
    localparam int NW = $clog2(MAX_TIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_WALK, S_WB, S_HDR, S_TIE, S_ERR
    } t_state;

    t_state         r_state;
    logic [N_W-1:0] r_max_n, r_next, r_n;
    logic [K_W-1:0] r_kc, r_pk;
    logic [T_W-1:0] r_tc, r_uc;
    logic           r_pv, r_stop, r_tet;
    logic [3:0]     r_best;
    logic [NW-1:0]  r_nt, r_i;

    t_bounds        bnd;
    logic           accept, in_err, adv, issue;
    logic [T_W-1:0] n_ext, rem;
    logic [3:0]     cand;
    logic [2:0]     tab_rdata;
    logic           tab_we;
    logic [AW-1:0]  tab_addr;
    logic [2:0]     tab_wdata;
    logic           tie_we;
    logic [TW-1:0]  tie_waddr, tie_raddr;
    logic [K_W-1:0] tie_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_max_n} : 32'd0;

    assign accept = start && !busy;
    assign in_err = (i_n_value == '0) || (i_n_value != r_next) || (i_n_value > r_max_n)
                    || (32'(i_n_value) >= MAX_TABLE);
    assign adv    = accept && !in_err;
    assign busy   = (r_state != S_IDLE);

    mtsc_bounds u_bounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_n     (i_n_value),
        .o_bnd   (bnd)
    );

    assign n_ext = T_W'(r_n);
    assign rem   = n_ext - r_tc;
    assign issue = (r_state == S_WALK) && !r_stop && (r_kc <= bnd.k2);
    assign cand  = 4'(tab_rdata) + 4'd2;

    always_comb begin
        tab_we    = 1'b0;
        tab_wdata = 3'(r_best - 4'd1);
        tab_addr  = AW'(rem);
        if (r_state == S_PREP) begin
            tab_we    = (T_W'(r_n) == bnd.t2);
            tab_wdata = '0;
            tab_addr  = AW'(r_n);
        end else if (r_state == S_WB) begin
            tab_we   = 1'b1;
            tab_addr = AW'(r_n);
        end
    end

    mtsc_ram #(.WIDTH(3), .DEPTH(MAX_TABLE)) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_addr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_addr),
        .o_rdata (tab_rdata)
    );

    always_comb begin
        tie_we    = 1'b0;
        tie_waddr = TW'(r_nt);
        if (r_state == S_WALK && r_pv && !r_stop) begin
            if (cand < r_best) begin
                tie_we    = 1'b1;
                tie_waddr = '0;
            end else if (cand == r_best && r_nt < NW'(MAX_TIES)) begin
                tie_we = 1'b1;
            end
        end
        tie_raddr = (r_state == S_HDR) ? '0 : TW'(r_i + NW'(1));
    end

    mtsc_ram #(.WIDTH(K_W), .DEPTH(MAX_TIES)) u_ties (
        .i_clk   (i_clk),
        .i_we    (tie_we),
        .i_waddr (tie_waddr),
        .i_wdata (r_pk),
        .i_raddr (tie_raddr),
        .o_rdata (tie_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max_n <= 16'hFFFF;
            r_next  <= 16'd1;
            r_pv    <= 1'b0;
            r_stop  <= 1'b0;
            r_tet   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == 1'b0) begin
                r_max_n <= pwdata[15:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_n <= i_n_value;
                        if (in_err) begin
                            r_state <= S_ERR;
                        end else begin
                            r_next  <= r_next + 16'd1;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_tet  <= (T_W'(r_n) == bnd.t2);
                    r_kc   <= bnd.k1;
                    r_tc   <= bnd.t1;
                    r_uc   <= bnd.u1;
                    r_best <= (T_W'(r_n) == bnd.t2) ? 4'd1 : BEST_INIT;
                    r_nt   <= '0;
                    r_stop <= 1'b0;
                    r_pv   <= 1'b0;
                    r_state <= (T_W'(r_n) == bnd.t2) ? S_HDR : S_WALK;
                end
                S_WALK: begin
                    r_pv <= issue;
                    if (issue) begin
                        r_pk <= r_kc;
                        r_kc <= r_kc + K_W'(1);
                        r_tc <= r_tc + r_uc;
                        r_uc <= r_uc + T_W'(r_kc) + T_W'(2);
                    end
                    if (r_pv && !r_stop) begin
                        if (cand < r_best) begin
                            r_best <= cand;
                            r_nt   <= NW'(1);
                            r_stop <= (cand == BEST_STOP);
                        end else if (cand == r_best && r_nt < NW'(MAX_TIES)) begin
                            r_nt <= r_nt + NW'(1);
                        end
                    end
                    if (!issue && !r_pv) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_HDR;
                end
                S_HDR: begin
                    r_i     <= '0;
                    r_state <= (!r_tet && r_nt == '0) ? S_IDLE : S_TIE;
                end
                S_TIE: begin
                    r_i <= r_i + NW'(1);
                    if (r_tet || (r_i + NW'(1) == r_nt)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ERR: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_valid  = 1'b0;
        o_kind   = KIND_HDR;
        o_n_echo = r_n;
        o_value  = 8'(r_best);
        o_last   = 1'b0;
        unique case (r_state)
            S_HDR: begin
                o_valid = 1'b1;
                o_last  = !r_tet && (r_nt == '0);
            end
            S_TIE: begin
                o_valid = 1'b1;
                o_kind  = KIND_TERM;
                o_value = r_tet ? bnd.k2 : tie_rdata;
                o_last  = r_tet || (r_i + NW'(1) == r_nt);
            end
            S_ERR: begin
                o_valid = 1'b1;
                o_kind  = KIND_ERR;
                o_value = '0;
                o_last  = 1'b1;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

    `MTSC_ASSERT(a_out_busy, i_clk, i_rst_n, !o_valid || busy, "result while idle")
    `MTSC_ASSERT(a_last_gap, i_clk, i_rst_n, o_valid && o_last |=> !o_valid, "word after last")
    `MTSC_ASSERT(a_err_last, i_clk, i_rst_n, o_valid && o_kind == KIND_ERR |-> o_last, "error not last")
    `MTSC_NEVER(a_ties_max, i_clk, i_rst_n, r_nt > NW'(MAX_TIES), "tie count overflow")

endmodule

[dv/tb_min_tetrahedral_sum_count.sv]
// testbench for min_tetrahedral_sum_count: consecutive n words with random gaps, error words,
// max_n register changes; results checked against a built-in tetrahedral sum predictor
// depends on mtsc_pkg and the min_tetrahedral_sum_count rtl
module tb_min_tetrahedral_sum_count;
    import mtsc_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] n;
        logic [7:0]  value;
        logic        last;
    } t_result;

    class tet_sum_board;
        bit [2:0]  count_code [65536];
        bit [15:0] next_n;
        bit [15:0] max_n;
        t_result   pending [$];
        int        errors;
        int        results_seen;

        function new();
            foreach (count_code[i]) count_code[i] = 3'd7;
            next_n = 1;
            max_n = 16'hffff;
            errors = 0;
            results_seen = 0;
        endfunction

        function int unsigned tet(int unsigned k);
            return (k * (k + 1) * (k + 2)) / 6;
        endfunction

        function int unsigned cube_root(int unsigned m);
            int unsigned k;
            k = 0;
            while ((k + 1) * (k + 1) * (k + 1) <= m) k++;
            return k;
        endfunction

        function void add(logic [1:0] kind, logic [15:0] n, int unsigned value, logic last);
            t_result r;
            r.kind = kind;
            r.n = n;
            r.value = value[7:0];
            r.last = last;
            pending.push_back(r);
        endfunction

        function void note_word(logic [15:0] n);
            int unsigned k1, k2, k, best, cand, t, rem;
            int unsigned ties [$];
            if (n == 0 || n != next_n || n > max_n) begin
                add(KIND_ERR, n, 0, 1'b1);
                return;
            end
            next_n = n + 16'd1;
            k1 = cube_root((6 * n) / 8);
            k2 = cube_root(6 * n);
            while (k2 > 0 && n < tet(k2)) k2--;
            if (n == tet(k2)) begin
                count_code[n] = 3'd0;
                add(KIND_HDR, n, 1, 1'b0);
                add(KIND_TERM, n, k2, 1'b1);
                return;
            end
            best = count_code[n] + 1;
            for (k = k1; k <= k2; k++) begin
                t = tet(k);
                rem = (t <= n) ? n - t : 0;
                cand = count_code[rem] + 2;
                if (cand < best) begin
                    best = cand;
                    count_code[n] = best - 1;
                    ties.delete();
                    ties.push_back(k);
                end else if (cand == best && ties.size() < 39) begin
                    ties.push_back(k);
                end
                if (best == 2) break;
            end
            add(KIND_HDR, n, best, ties.size() == 0);
            foreach (ties[i]) add(KIND_TERM, n, ties[i], i == ties.size() - 1);
        endfunction

        function void check_result(logic [1:0] kind, logic [15:0] n, logic [7:0] value,
                                   logic last);
            t_result e;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result kind=%0d n=%0d value=%0d", kind, n, value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d actual %0d", e.kind, kind);
                errors++;
            end
            if (n !== e.n) begin
                $error("n_echo: expected %0d actual %0d", e.n, n);
                errors++;
            end
            if (value !== e.value) begin
                $error("value: expected %0d actual %0d", e.value, value);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic [N_W-1:0] i_n_value = '0;
    logic           o_valid;
    logic [1:0]     o_kind;
    logic [N_W-1:0] o_n_echo;
    logic [7:0]     o_value;
    logic           o_last;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    localparam logic [2:0] ADDR_MAX_N = 3'd0;

    tet_sum_board board = new();
    int  cycles = 0;
    int  words_sent = 0;
    bit  no_gaps = 0;

    min_tetrahedral_sum_count dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 300000) begin
            $display("min_tetrahedral_sum_count test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_kind, o_n_echo, o_value, o_last);
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task send_word(logic [15:0] n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_n_value <= n;
        do @(posedge i_clk); while (busy);
        board.note_word(n);
        words_sent++;
    endtask

    task drain();
        start <= 1'b0;
        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_max_n(logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_MAX_N;
        pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.max_n = v;
        @(posedge i_clk);
    endtask

    initial begin
        int r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest limit: only n=1 fits
        write_max_n(16'd1);
        send_word(16'd1);
        send_word(16'd2);
        send_word(16'd0);
        send_word(16'hffff);
        drain();

        write_max_n(16'hffff);
        for (int n = 2; n <= 20; n++) send_word(n);
        send_word(16'd5);
        send_word(16'd22);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            no_gaps = (phase == 2);
            if (phase == 3) write_max_n(16'hffff);
            else write_max_n(board.next_n + $urandom_range(0, 30));
            for (int i = 0; i < 36; i++) begin
                r = $urandom_range(0, 99);
                if (r < 80) send_word(board.next_n);
                else if (r < 85) send_word(16'd0);
                else if (r < 90) send_word(board.next_n + 16'd1);
                else if (r < 94) send_word(board.next_n - 16'd1);
                else send_word($urandom_range(0, 65535));
            end
            drain();
        end

        $display("sent %0d words, n reached %0d, %0d results checked",
                 words_sent, board.next_n - 1, board.results_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("min_tetrahedral_sum_count test passed");
        end else begin
            $display("min_tetrahedral_sum_count test failed");
        end
        $finish;
    end
endmodule
